FILE: src/tdse_pkg.sv
// ----------------------------------------------------------------------------
// tdse_pkg
// Shared types, constants and helpers of the terminal diff SGR encoder.
// ----------------------------------------------------------------------------
package tdse_pkg;

    localparam int NITEM = 17;

    localparam logic [4:0] IT_RST0  = 5'd0;
    localparam logic [4:0] IT_MOVE  = 5'd1;
    localparam logic [4:0] IT_OPEN  = 5'd2;
    localparam logic [4:0] IT_ZERO  = 5'd3;
    localparam logic [4:0] IT_ON0   = 5'd4;
    localparam logic [4:0] IT_ON1   = 5'd5;
    localparam logic [4:0] IT_ON2   = 5'd6;
    localparam logic [4:0] IT_ON3   = 5'd7;
    localparam logic [4:0] IT_OFF0  = 5'd8;
    localparam logic [4:0] IT_OFF1  = 5'd9;
    localparam logic [4:0] IT_OFF2  = 5'd10;
    localparam logic [4:0] IT_OFF3  = 5'd11;
    localparam logic [4:0] IT_FG    = 5'd12;
    localparam logic [4:0] IT_BG    = 5'd13;
    localparam logic [4:0] IT_CLOSE = 5'd14;
    localparam logic [4:0] IT_CHAR  = 5'd15;
    localparam logic [4:0] IT_RST1  = 5'd16;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;

    // Style groups in emission order: bold, italic, underline, struck.
    localparam logic [3:0][15:0] GRP = {16'h0001, 16'h000C, 16'h0010, 16'h0002};
    localparam logic [3:0][7:0] ON_CHR  = {8'h39, 8'h34, 8'h33, 8'h31};
    localparam logic [3:0][7:0] OFF_CHR = {8'h39, 8'h34, 8'h33, 8'h32};

    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][3:0] d;
    } t_dec;

    typedef struct packed {
        logic [NITEM-1:0] mask;
        t_dec             row;
        t_dec             col;
        logic             fg_def;
        t_dec [2:0]       fg;
        logic             bg_def;
        t_dec [2:0]       bg;
        logic [7:0]       chr;
    } t_rec;

    // Decimal digits of a value below 1000, most significant printed digit first.
    function automatic t_dec to_dec(input logic [9:0] v);
        logic [15:0] ph;
        logic [3:0]  h;
        logic [6:0]  r;
        logic [14:0] pt;
        logic [3:0]  tn;
        logic [3:0]  o;
        t_dec        res;
        ph = 16'(v) * 16'd41;
        h  = ph[15:12];
        r  = 7'(v - 10'(h) * 10'd100);
        pt = 15'(r) * 15'd205;
        tn = pt[14:11];
        o  = 4'(r - 7'(tn) * 7'd10);
        if (h != 4'd0) begin
            res.n = 2'd3;
            res.d = {o, tn, h};
        end else if (tn != 4'd0) begin
            res.n = 2'd2;
            res.d = {4'd0, o, tn};
        end else begin
            res.n = 2'd1;
            res.d = {4'd0, 4'd0, o};
        end
        return res;
    endfunction

    function automatic logic [7:0] dig(input t_dec v, input logic [1:0] i);
        logic [3:0] d;
        case (i)
            2'd0: d = v.d[0];
            2'd1: d = v.d[1];
            2'd2: d = v.d[2];
            default: d = 4'd0;
        endcase
        return CH_0 + {4'd0, d};
    endfunction

endpackage

FILE: src/tdse_front.sv
// ----------------------------------------------------------------------------
// tdse_front
// Accepts cells, tracks pen, cursor and scan position, and builds one
// command record per cell that causes output.
// ----------------------------------------------------------------------------
module tdse_front #(
    parameter int MAX_DIM = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_prev_char,
    input  logic               i_prev_fg_default,
    input  logic [23:0]        i_prev_fg_rgb,
    input  logic               i_prev_bg_default,
    input  logic [23:0]        i_prev_bg_rgb,
    input  logic [15:0]        i_prev_style,
    input  logic [7:0]         i_cur_char,
    input  logic               i_cur_fg_default,
    input  logic [23:0]        i_cur_fg_rgb,
    input  logic               i_cur_bg_default,
    input  logic [23:0]        i_cur_bg_rgb,
    input  logic [15:0]        i_cur_style,
    output logic               o_q_push,
    output tdse_pkg::t_rec     o_q_rec,
    input  logic               i_q_full
);
    import tdse_pkg::*;

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int SW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [8:0]    r_rows, r_cols;
    logic          r_pen_fgd, r_pen_bgd;
    logic [23:0]   r_pen_fgc, r_pen_bgc;
    logic [15:0]   r_pen_sty;
    logic          r_cur_known;
    logic [SW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [SW-1:0] r_scan_row, r_scan_col;

    logic [CW-1:0] rows_eff, cols_eff, y_p1, x_p1;
    logic          accept, first, same, known, move, last_col, last_row;
    logic          pfd, pbd, cfgc, cbgc, sgr_do, rst, fgi, bgi, any;
    logic [23:0]   pfc, pbc;
    logic [15:0]   pst, ps, off;
    logic [3:0]    g_off, on, offm;
    logic [NITEM-1:0] mask;

    always_comb begin
        if (r_rows == 9'd0) begin
            rows_eff = CW'(1);
        end else if (10'(r_rows) > 10'(MAX_DIM)) begin
            rows_eff = CW'(MAX_DIM);
        end else begin
            rows_eff = CW'(r_rows);
        end
        if (r_cols == 9'd0) begin
            cols_eff = CW'(1);
        end else if (10'(r_cols) > 10'(MAX_DIM)) begin
            cols_eff = CW'(MAX_DIM);
        end else begin
            cols_eff = CW'(r_cols);
        end
    end

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign y_p1     = CW'(r_scan_row) + CW'(1);
    assign x_p1     = CW'(r_scan_col) + CW'(1);
    assign last_col = x_p1 >= cols_eff;
    assign last_row = y_p1 >= rows_eff;
    assign first    = (r_scan_row == '0) && (r_scan_col == '0);

    always_comb begin
        pfd   = first ? 1'b1 : r_pen_fgd;
        pbd   = first ? 1'b1 : r_pen_bgd;
        pfc   = first ? 24'd0 : r_pen_fgc;
        pbc   = first ? 24'd0 : r_pen_bgc;
        pst   = first ? 16'd0 : r_pen_sty;
        known = first ? 1'b0 : r_cur_known;
        same  = (i_prev_char == i_cur_char) && (i_prev_fg_default == i_cur_fg_default)
                && (i_prev_fg_default || (i_prev_fg_rgb == i_cur_fg_rgb))
                && (i_prev_bg_default == i_cur_bg_default)
                && (i_prev_bg_default || (i_prev_bg_rgb == i_cur_bg_rgb))
                && (i_prev_style == i_cur_style);
        move  = !same && (!known || (r_cur_row != r_scan_row)
                || (r_cur_col != CW'(r_scan_col)));
        cfgc  = i_cur_fg_default ? !pfd : (pfd || (pfc != i_cur_fg_rgb));
        cbgc  = i_cur_bg_default ? !pbd : (pbd || (pbc != i_cur_bg_rgb));
        sgr_do = !same && (cfgc || cbgc || (pst != i_cur_style));
        off   = pst & ~i_cur_style;
        for (int i = 0; i < 4; i++) begin
            g_off[i] = (off & GRP[i]) != 16'd0;
        end
        rst = $countones(g_off) >= 2;
        ps  = rst ? 16'd0 : pst;
        for (int i = 0; i < 4; i++) begin
            on[i]   = ((i_cur_style & GRP[i]) != 16'd0) && ((ps & GRP[i]) == 16'd0);
            offm[i] = !rst && ((i_cur_style & GRP[i]) == 16'd0) && ((ps & GRP[i]) != 16'd0);
        end
        fgi = rst ? !i_cur_fg_default : cfgc;
        bgi = rst ? !i_cur_bg_default : cbgc;
        any = rst || (on != 4'd0) || (offm != 4'd0) || fgi || bgi;
        mask = '0;
        mask[IT_RST0] = first;
        mask[IT_MOVE] = move;
        mask[IT_OPEN] = sgr_do && any;
        mask[IT_ZERO] = sgr_do && rst;
        mask[IT_ON3:IT_ON0]   = sgr_do ? on : 4'd0;
        mask[IT_OFF3:IT_OFF0] = sgr_do ? offm : 4'd0;
        mask[IT_FG]    = sgr_do && fgi;
        mask[IT_BG]    = sgr_do && bgi;
        mask[IT_CLOSE] = sgr_do && any;
        mask[IT_CHAR]  = !same;
        mask[IT_RST1]  = last_row && last_col;
    end

    always_comb begin
        o_q_rec.mask   = mask;
        o_q_rec.row    = to_dec(10'(y_p1));
        o_q_rec.col    = to_dec(10'(x_p1));
        o_q_rec.fg_def = i_cur_fg_default;
        o_q_rec.fg[0]  = to_dec(10'(i_cur_fg_rgb[23:16]));
        o_q_rec.fg[1]  = to_dec(10'(i_cur_fg_rgb[15:8]));
        o_q_rec.fg[2]  = to_dec(10'(i_cur_fg_rgb[7:0]));
        o_q_rec.bg_def = i_cur_bg_default;
        o_q_rec.bg[0]  = to_dec(10'(i_cur_bg_rgb[23:16]));
        o_q_rec.bg[1]  = to_dec(10'(i_cur_bg_rgb[15:8]));
        o_q_rec.bg[2]  = to_dec(10'(i_cur_bg_rgb[7:0]));
        o_q_rec.chr    = (i_cur_char == 8'd0) ? CH_SPACE : i_cur_char;
    end

    assign o_q_push = accept && (mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 9'd24;
            r_cols      <= 9'd80;
            r_pen_fgd   <= 1'b1;
            r_pen_bgd   <= 1'b1;
            r_pen_fgc   <= 24'd0;
            r_pen_bgc   <= 24'd0;
            r_pen_sty   <= 16'd0;
            r_cur_known <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_scan_row  <= '0;
            r_scan_col  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: r_rows <= r_rows;
            endcase
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (accept) begin
            if (sgr_do) begin
                r_pen_fgd <= i_cur_fg_default;
                r_pen_bgd <= i_cur_bg_default;
                r_pen_fgc <= i_cur_fg_rgb;
                r_pen_bgc <= i_cur_bg_rgb;
                r_pen_sty <= i_cur_style;
            end else if (first) begin
                r_pen_fgd <= 1'b1;
                r_pen_bgd <= 1'b1;
                r_pen_fgc <= 24'd0;
                r_pen_bgc <= 24'd0;
                r_pen_sty <= 16'd0;
            end
            if (!same) begin
                r_cur_known <= 1'b1;
                r_cur_row   <= r_scan_row;
                r_cur_col   <= x_p1;
            end else if (first) begin
                r_cur_known <= 1'b0;
            end
            if (last_row && last_col) begin
                r_scan_row <= '0;
                r_scan_col <= '0;
            end else if (last_col) begin
                r_scan_row <= SW'(y_p1);
                r_scan_col <= '0;
            end else begin
                r_scan_col <= SW'(x_p1);
            end
        end
    end

endmodule

FILE: src/tdse_cmdq.sv
// ----------------------------------------------------------------------------
// tdse_cmdq
// Two-entry queue of command records between the front and back parts.
// ----------------------------------------------------------------------------
module tdse_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tdse_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_valid,
    output tdse_pkg::t_rec o_rec,
    input  logic           i_pop
);
    import tdse_pkg::*;

    t_rec       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: src/tdse_back.sv
// ----------------------------------------------------------------------------
// tdse_back
// Walks the text pieces of one command record and sends one byte per cycle unless pop stalls.
// ----------------------------------------------------------------------------
module tdse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tdse_pkg::t_rec i_q_rec,
    output logic           o_q_pop,
    output logic           o_empty,
    output logic [7:0]     o_byte,
    output logic           o_last,
    input  logic           i_pop
);
    import tdse_pkg::*;

    t_rec             r_rec;
    logic [NITEM-1:0] r_mask;
    logic [4:0]       r_t;
    logic             r_sep, r_busy, r_ovalid, r_olast;
    logic [5:0]       r_cnt;
    logic [7:0]       r_obyte;

    logic [4:0]       cur, tp, len, u, a, b, tl;
    logic [NITEM-1:0] cur_oh;
    logic             sep_need, item_end, last, adv, ld;
    logic [7:0]       tb;
    t_dec [2:0]       comp;

    assign ld      = !r_busy && i_q_valid;
    assign o_q_pop = ld;
    assign adv     = r_busy && (!r_ovalid || i_pop);
    assign o_empty = !r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

    always_comb begin
        cur = 5'd0;
        for (int i = NITEM - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                cur = 5'(i);
            end
        end
        cur_oh   = NITEM'(1) << cur;
        sep_need = r_sep && (cur >= IT_ON0) && (cur <= IT_BG);
        tp       = sep_need ? r_t - 5'd1 : r_t;
        comp     = (cur == IT_FG) ? r_rec.fg : r_rec.bg;
        u        = tp - 5'd5;
        a        = 5'(comp[0].n);
        b        = a + 5'd1 + 5'(comp[1].n);
        tl       = 5'd1;
        tb       = CH_M;
        case (cur)
            IT_RST0, IT_RST1: begin
                tl = 5'd4;
                case (tp)
                    5'd0: tb = CH_ESC;
                    5'd1: tb = CH_LBR;
                    5'd2: tb = CH_0;
                    default: tb = CH_M;
                endcase
            end
            IT_MOVE: begin
                tl = 5'd4 + 5'(r_rec.row.n) + 5'(r_rec.col.n);
                if (tp == 5'd0) begin
                    tb = CH_ESC;
                end else if (tp == 5'd1) begin
                    tb = CH_LBR;
                end else if (tp < 5'd2 + 5'(r_rec.row.n)) begin
                    tb = dig(r_rec.row, 2'(tp - 5'd2));
                end else if (tp == 5'd2 + 5'(r_rec.row.n)) begin
                    tb = CH_SEMI;
                end else if (tp < tl - 5'd1) begin
                    tb = dig(r_rec.col, 2'(tp - 5'd3 - 5'(r_rec.row.n)));
                end else begin
                    tb = CH_H;
                end
            end
            IT_OPEN: begin
                tl = 5'd2;
                tb = (tp == 5'd0) ? CH_ESC : CH_LBR;
            end
            IT_ZERO: tb = CH_0;
            IT_ON0, IT_ON1, IT_ON2, IT_ON3: tb = ON_CHR[2'(cur - IT_ON0)];
            IT_OFF0, IT_OFF1, IT_OFF2, IT_OFF3: begin
                tl = 5'd2;
                tb = (tp == 5'd0) ? 8'h32 : OFF_CHR[2'(cur - IT_OFF0)];
            end
            IT_FG, IT_BG: begin
                if ((cur == IT_FG) ? r_rec.fg_def : r_rec.bg_def) begin
                    tl = 5'd2;
                    tb = (tp == 5'd0) ? ((cur == IT_FG) ? 8'h33 : 8'h34) : 8'h39;
                end else begin
                    tl = 5'd7 + 5'(comp[0].n) + 5'(comp[1].n) + 5'(comp[2].n);
                    case (tp)
                        5'd0: tb = (cur == IT_FG) ? 8'h33 : 8'h34;
                        5'd1: tb = 8'h38;
                        5'd2: tb = CH_SEMI;
                        5'd3: tb = 8'h32;
                        5'd4: tb = CH_SEMI;
                        default: begin
                            if (u < a) begin
                                tb = dig(comp[0], 2'(u));
                            end else if (u == a) begin
                                tb = CH_SEMI;
                            end else if (u < b) begin
                                tb = dig(comp[1], 2'(u - a - 5'd1));
                            end else if (u == b) begin
                                tb = CH_SEMI;
                            end else begin
                                tb = dig(comp[2], 2'(u - b - 5'd1));
                            end
                        end
                    endcase
                end
            end
            IT_CLOSE: tb = CH_M;
            IT_CHAR: tb = r_rec.chr;
            default: tb = CH_M;
        endcase
        if (sep_need && (r_t == 5'd0)) begin
            tb = CH_SEMI;
        end
        len      = tl + 5'(sep_need);
        item_end = r_t == len - 5'd1;
        last     = (item_end && ((r_mask & ~cur_oh) == '0)) || (r_cnt == 6'd62);
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_rec <= i_q_rec;
        end
        if (adv) begin
            r_obyte <= tb;
            r_olast <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_mask   <= '0;
            r_t      <= 5'd0;
            r_sep    <= 1'b0;
            r_cnt    <= 6'd0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            if (ld) begin
                r_busy <= 1'b1;
                r_mask <= i_q_rec.mask;
                r_t    <= 5'd0;
                r_sep  <= 1'b0;
                r_cnt  <= 6'd0;
            end else if (adv) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end else if (item_end) begin
                    r_mask <= r_mask & ~cur_oh;
                    r_t    <= 5'd0;
                    if ((cur >= IT_ZERO) && (cur <= IT_BG)) begin
                        r_sep <= 1'b1;
                    end
                end else begin
                    r_t <= r_t + 5'd1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 6'd62)
        else $error("Byte count of a cell passed its cap.");
    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_mask != '0)
        else $error("Busy with no text pieces left.");
    a_cap_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_cnt == 6'd62) |=> !r_busy && r_olast)
        else $error("Capped cell did not end its byte run.");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && last) |=> !r_busy)
        else $error("Busy after the last byte of a cell.");
`endif

endmodule

FILE: src/terminal_diff_sgr_encoder_top.sv
// ----------------------------------------------------------------------------
// terminal_diff_sgr_encoder_top
// ANSI diff renderer: one screen cell per item in, terminal bytes out.
// ----------------------------------------------------------------------------
// Cells enter in row-major order through push/full; an item is taken when
// push is high and full is low. Bytes leave through empty/pop; the oldest
// byte sits on o_out_byte while empty is low and o_run_last marks the last
// byte a cell causes. The configuration port writes row and column counts
// and restarts the scan at the first cell of a frame.
// An item is classified at once, combinationally, into a command record
// held in a two-entry queue. The back part sends one byte per cycle unless
// pop stalls it, and loads each record before its first byte; the first
// byte goes through the queue, the record register and the output register.
// Unchanged cells in mid-frame cause no record and pass at one per cycle
// while the queue is not full. The byte sequencer sets the throughput.
// Reset restores 24 rows by 80 columns, the default pen, an unknown cursor
// and the first cell of a frame, and empties the record queue and the output
// byte. When pop stays low the output byte holds, the back part waits and
// full rises once the record queue holds two records.
// ----------------------------------------------------------------------------
module terminal_diff_sgr_encoder_top #(
    parameter int MAX_DIM = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_prev_char,
    input  logic        i_prev_fg_default,
    input  logic [23:0] i_prev_fg_rgb,
    input  logic        i_prev_bg_default,
    input  logic [23:0] i_prev_bg_rgb,
    input  logic [15:0] i_prev_style,
    input  logic [7:0]  i_cur_char,
    input  logic        i_cur_fg_default,
    input  logic [23:0] i_cur_fg_rgb,
    input  logic        i_cur_bg_default,
    input  logic [23:0] i_cur_bg_rgb,
    input  logic [15:0] i_cur_style,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last
);
    import tdse_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    t_rec q_in, q_out;

    tdse_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .o_full            (full),
        .i_prev_char       (i_prev_char),
        .i_prev_fg_default (i_prev_fg_default),
        .i_prev_fg_rgb     (i_prev_fg_rgb),
        .i_prev_bg_default (i_prev_bg_default),
        .i_prev_bg_rgb     (i_prev_bg_rgb),
        .i_prev_style      (i_prev_style),
        .i_cur_char        (i_cur_char),
        .i_cur_fg_default  (i_cur_fg_default),
        .i_cur_fg_rgb      (i_cur_fg_rgb),
        .i_cur_bg_default  (i_cur_bg_default),
        .i_cur_bg_rgb      (i_cur_bg_rgb),
        .i_cur_style       (i_cur_style),
        .o_q_push          (q_push),
        .o_q_rec           (q_in),
        .i_q_full          (q_full)
    );

    tdse_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_out),
        .i_pop   (q_pop)
    );

    tdse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_byte    (o_out_byte),
        .o_last    (o_run_last),
        .i_pop     (pop)
    );

endmodule

FILE: tb/sv/terminal_diff_sgr_encoder_top_test.sv
// ----------------------------------------------------------------------------
// terminal_diff_sgr_encoder_top_test
// Self-checking testbench of the terminal diff SGR encoder.
// ----------------------------------------------------------------------------
// Screen cells are pushed in frame order. A scoreboard tracks the pen, the
// cursor and the scan position, and predicts the ANSI bytes of every item.
// Each popped byte is compared with the oldest predicted byte. Both sides
// idle at random. The receiver stalls once for a long stretch. The frame size
// changes between phases, including zero and oversized dimensions.
// ----------------------------------------------------------------------------
module terminal_diff_sgr_encoder_top_test;
    import tdse_pkg::*;

    typedef struct packed {
        logic [7:0]  p_chr;
        logic        p_fgd;
        logic [23:0] p_fg;
        logic        p_bgd;
        logic [23:0] p_bg;
        logic [15:0] p_sty;
        logic [7:0]  c_chr;
        logic        c_fgd;
        logic [23:0] c_fg;
        logic        c_bgd;
        logic [23:0] c_bg;
        logic [15:0] c_sty;
    } t_cell;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_stream_byte;

    class t_sgr_scoreboard;
        logic [8:0]   rows_reg = 9'd24;
        logic [8:0]   cols_reg = 9'd80;
        logic         pen_fgd = 1'b1;
        logic [23:0]  pen_fg = '0;
        logic         pen_bgd = 1'b1;
        logic [23:0]  pen_bg = '0;
        logic [15:0]  pen_sty = '0;
        logic         cur_known = 1'b0;
        int           cur_row = 0;
        int           cur_col = 0;
        int           scan_row = 0;
        int           scan_col = 0;
        logic [7:0]   line[$];
        bit           no_param;
        t_stream_byte bytes_due[$];
        int           errors = 0;
        logic [15:0]  grp[4] = '{16'h0002, 16'h0010, 16'h000C, 16'h0001};
        int           on_code[4] = '{1, 3, 4, 9};
        int           off_code[4] = '{22, 23, 24, 29};

        function void put_num(int v);
            string s;
            s = $sformatf("%0d", v);
            for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
        endfunction

        function void sep();
            if (!no_param) line.push_back(CH_SEMI);
            no_param = 1'b0;
        endfunction

        function void put_code(int v);
            sep();
            put_num(v);
        endfunction

        function void put_rgb(int lead, logic [23:0] c);
            put_code(lead);
            line.push_back(CH_SEMI);
            put_num(2);
            line.push_back(CH_SEMI);
            put_num(c[23:16]);
            line.push_back(CH_SEMI);
            put_num(c[15:8]);
            line.push_back(CH_SEMI);
            put_num(c[7:0]);
        endfunction

        function void put_reset();
            line.push_back(CH_ESC);
            line.push_back(CH_LBR);
            line.push_back(CH_0);
            line.push_back(CH_M);
        endfunction

        function int eff_dim(logic [8:0] v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return v;
        endfunction

        function void set_reg(logic idx, logic [8:0] v);
            if (idx == CFG_ROWS) rows_reg = v;
            else cols_reg = v;
            scan_row = 0;
            scan_col = 0;
        endfunction

        function void sgr(t_cell c);
            bit          chg_fg, chg_bg, clear;
            int          noff, start;
            logic [15:0] off, ps;
            chg_fg = c.c_fgd ? !pen_fgd : (pen_fgd || pen_fg != c.c_fg);
            chg_bg = c.c_bgd ? !pen_bgd : (pen_bgd || pen_bg != c.c_bg);
            if (!chg_fg && !chg_bg && pen_sty == c.c_sty) return;
            off = pen_sty & ~c.c_sty;
            noff = 0;
            for (int i = 0; i < 4; i++) if ((off & grp[i]) != 0) noff++;
            clear = noff >= 2;
            start = line.size();
            no_param = 1'b1;
            line.push_back(CH_ESC);
            line.push_back(CH_LBR);
            ps = pen_sty;
            if (clear) begin
                put_code(0);
                ps = '0;
                chg_fg = !c.c_fgd;
                chg_bg = !c.c_bgd;
            end
            for (int i = 0; i < 4; i++)
                if ((c.c_sty & grp[i]) != 0 && (ps & grp[i]) == 0) put_code(on_code[i]);
            if (!clear)
                for (int i = 0; i < 4; i++)
                    if ((c.c_sty & grp[i]) == 0 && (ps & grp[i]) != 0) put_code(off_code[i]);
            if (chg_fg) begin
                if (c.c_fgd) put_code(39);
                else put_rgb(38, c.c_fg);
            end
            if (chg_bg) begin
                if (c.c_bgd) put_code(49);
                else put_rgb(48, c.c_bg);
            end
            if (no_param) begin
                while (line.size() > start) void'(line.pop_back());
            end else begin
                line.push_back(CH_M);
            end
            pen_fgd = c.c_fgd;
            pen_fg = c.c_fg;
            pen_bgd = c.c_bgd;
            pen_bg = c.c_bg;
            pen_sty = c.c_sty;
        endfunction

        function void note_cell(t_cell c);
            int rows, cols, y, x, n;
            bit same;
            rows = eff_dim(rows_reg);
            cols = eff_dim(cols_reg);
            y = scan_row;
            x = scan_col;
            line.delete();
            if (y == 0 && x == 0) begin
                put_reset();
                pen_fgd = 1'b1;
                pen_fg = '0;
                pen_bgd = 1'b1;
                pen_bg = '0;
                pen_sty = '0;
                cur_known = 1'b0;
            end
            same = c.p_chr == c.c_chr && c.p_fgd == c.c_fgd && (c.p_fgd || c.p_fg == c.c_fg)
                && c.p_bgd == c.c_bgd && (c.p_bgd || c.p_bg == c.c_bg) && c.p_sty == c.c_sty;
            if (!same) begin
                if (!cur_known || cur_row != y || cur_col != x) begin
                    line.push_back(CH_ESC);
                    line.push_back(CH_LBR);
                    put_num(y + 1);
                    line.push_back(CH_SEMI);
                    put_num(x + 1);
                    line.push_back(CH_H);
                end
                sgr(c);
                line.push_back(c.c_chr != 0 ? c.c_chr : CH_SPACE);
                cur_known = 1'b1;
                cur_row = y;
                cur_col = x + 1;
            end
            if (y + 1 >= rows && x + 1 >= cols) begin
                put_reset();
                scan_row = 0;
                scan_col = 0;
            end else if (x + 1 >= cols) begin
                scan_col = 0;
                scan_row = y + 1;
            end else begin
                scan_col = x + 1;
            end
            n = line.size() > 63 ? 63 : line.size();
            for (int k = 0; k < n; k++) bytes_due.push_back('{line[k], k + 1 == n});
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            t_stream_byte w;
            if (bytes_due.size() == 0) begin
                if (errors < 10) $display("unexpected byte %h last %b", b, last);
                errors++;
                return;
            end
            w = bytes_due.pop_front();
            if (w.b !== b || w.last !== last) begin
                if (errors < 10)
                    $display("byte mismatch: expected %h last %b, got %h last %b",
                             w.b, w.last, b, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    t_cell       drv = '0;

    t_sgr_scoreboard sb = new();
    int  hold_cycles = 0;
    int  rx_gap = 0;
    bit  calm = 1'b0;
    bit  running = 1'b0;
    longint cycles = 0;

    terminal_diff_sgr_encoder_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_prev_char(drv.p_chr), .i_prev_fg_default(drv.p_fgd), .i_prev_fg_rgb(drv.p_fg),
        .i_prev_bg_default(drv.p_bgd), .i_prev_bg_rgb(drv.p_bg), .i_prev_style(drv.p_sty),
        .i_cur_char(drv.c_chr), .i_cur_fg_default(drv.c_fgd), .i_cur_fg_rgb(drv.c_fg),
        .i_cur_bg_default(drv.c_bgd), .i_cur_bg_rgb(drv.c_bg), .i_cur_style(drv.c_sty),
        .empty(empty), .pop(pop), .o_out_byte(o_out_byte), .o_run_last(o_run_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if (pop && !empty) begin
                sb.check_byte(o_out_byte, o_run_last);
                rx_gap = calm ? 0 : $urandom_range(0, 15);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_cell(t_cell c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drv <= c;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_cell(c);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [8:0] rows, logic [8:0] cols);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        sb.set_reg(CFG_ROWS, rows);
        i_cfg_idx <= CFG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        sb.set_reg(CFG_COLS, cols);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_style();
        logic [15:0] s;
        s = '0;
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        if ($urandom_range(0, 1) != 0) s |= 16'h0001;
        if ($urandom_range(0, 1) != 0) s |= 16'h0002;
        if ($urandom_range(0, 1) != 0) s |= 16'h0010;
        case ($urandom_range(0, 3))
            0: s |= 16'h0004;
            1: s |= 16'h0008;
            2: s |= 16'h000C;
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [23:0] rand_rgb();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        c.p_chr = $urandom_range(0, 9) == 0 ? 8'h00 : 8'($urandom);
        c.p_fgd = 1'($urandom_range(0, 1));
        c.p_fg = rand_rgb();
        c.p_bgd = 1'($urandom_range(0, 1));
        c.p_bg = rand_rgb();
        c.p_sty = rand_style();
        c.c_chr = c.p_chr;
        c.c_fgd = c.p_fgd;
        c.c_fg = c.p_fgd && $urandom_range(0, 1) != 0 ? rand_rgb() : c.p_fg;
        c.c_bgd = c.p_bgd;
        c.c_bg = c.p_bgd && $urandom_range(0, 1) != 0 ? rand_rgb() : c.p_bg;
        c.c_sty = c.p_sty;
        if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 5))
                    0: c.c_chr = $urandom_range(0, 9) == 0 ? 8'h00 : 8'($urandom);
                    1: c.c_fgd = 1'($urandom_range(0, 1));
                    2: c.c_fg = rand_rgb();
                    3: c.c_bgd = 1'($urandom_range(0, 1));
                    4: c.c_bg = rand_rgb();
                    default: c.c_sty = rand_style();
                endcase
            end
        end
        return c;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_cell(rand_cell());
    endtask

    initial begin
        t_cell c;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);

        c = '0;
        c.p_fgd = 1'b1;
        c.p_bgd = 1'b1;
        c.c_fgd = 1'b1;
        c.c_bgd = 1'b1;
        send_cell(c);
        c.c_fg = 24'hFFFFFF;
        send_cell(c);
        c.c_chr = 8'hFF;
        c.c_sty = 16'h001F;
        send_cell(c);
        c.p_chr = 8'hFF;
        c.c_chr = 8'h00;
        c.c_fgd = 1'b0;
        c.c_bgd = 1'b0;
        c.c_bg = 24'h000000;
        c.c_sty = 16'h0000;
        send_cell(c);
        c.c_sty = 16'h0018;
        send_cell(c);
        c.c_sty = 16'h0014;
        send_cell(c);
        c.c_sty = 16'hFF14;
        send_cell(c);
        c.c_sty = 16'h0013;
        send_cell(c);
        c.c_chr = 8'h41;
        send_cell(c);
        c.c_sty = 16'h0001;
        c.c_fgd = 1'b1;
        c.c_fg = 24'h123456;
        send_cell(c);
        c.c_fgd = 1'b0;
        c.c_fg = 24'hFFFFFF;
        c.c_bg = 24'hFFFFFF;
        c.c_sty = 16'h0000;
        send_cell(c);
        c.c_sty = 16'hFFFF;
        c.c_fg = 24'h000000;
        send_cell(c);
        c.c_sty = 16'h0000;
        c.c_bgd = 1'b1;
        send_cell(c);
        c = '0;
        c.p_fg = 24'hFFFFFF;
        c.c_fg = 24'hFFFFFF;
        c.p_sty = 16'hFFFF;
        c.c_sty = 16'hFFFF;
        send_cell(c);
        send_random(6);
        drain();

        set_dims(9'd2, 9'd3);
        hold_cycles = 400;
        calm = 1'b1;
        send_random(40);
        calm = 1'b0;
        drain();

        set_dims(9'd0, 9'd0);
        send_random(20);
        drain();

        set_dims(9'd511, 9'd256);
        send_random(30);
        drain();

        set_dims(9'd256, 9'd1);
        send_random(20);
        drain();

        set_dims(9'd4, 9'd5);
        calm = 1'b1;
        send_random(15);
        calm = 1'b0;
        send_random(15);
        drain();
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
